>>> rtl/core/length_prefixed_packet_fifo_top_macros.svh
// Assertion macros used by the checker file.
`ifndef LENGTH_PREFIXED_PACKET_FIFO_TOP_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_FIFO_TOP_MACROS_SVH

// Check a property outside reset.
`define LPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define LPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/lpf_pkg.sv
package lpf_pkg;

  // Result status codes, as seen on out_tuser
  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_POP_EMPTY = 3'd1,
    ST_POP_BUSY  = 3'd2,
    ST_STORED    = 3'd3,
    ST_DROPPED   = 3'd4
  } status_t;

  // Input item kind, as seen on in_tuser
  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_POP  = 1'b1
  } mode_t;

  // Command kinds passed from front to back
  typedef enum logic {
    CMD_RESULT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_kind_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_HDR  = 2'd1,
    B_DATA = 2'd2
  } back_state_t;

  localparam int FREE_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // One queued command: a ready-made result or a packet pop
  typedef struct packed {
    cmd_kind_t          kind;
    status_t            status;
    logic [FREE_W-1:0]  free;
  } cmd_t;

endpackage

>>> rtl/core/lpf_ring.sv
module lpf_ring #(
  parameter int RING_DEPTH = 64,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [lpf_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [lpf_pkg::BYTE_W-1:0] rd_data
);

  logic [lpf_pkg::BYTE_W-1:0] mem [RING_DEPTH];
  logic [lpf_pkg::BYTE_W-1:0] rd_data_r;

  // Write one byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one byte, hold it until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/lpf_cmdq.sv
module lpf_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpf_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output lpf_pkg::cmd_t  head_cmd,
  output logic           full,
  output logic           empty
);

  lpf_pkg::cmd_t                 entry_r [lpf_pkg::QUEUE_DEPTH];
  logic [lpf_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [lpf_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [lpf_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == lpf_pkg::QCNT_W'(lpf_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/lpf_front.sv
module lpf_front #(
  parameter int RING_DEPTH = 64,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [15:0]                in_tdata,
  input  logic                       in_tlast,
  input  logic                       in_tuser,
  input  logic                       q_full,
  output logic                       q_push,
  output lpf_pkg::cmd_t              q_cmd,
  output logic                       wr_en,
  output logic [AW-1:0]              wr_addr,
  output logic [lpf_pkg::BYTE_W-1:0] wr_data,
  input  logic                       pop_done,
  input  logic [AW-1:0]              pop_tail,
  output logic [AW-1:0]              head_o,
  output logic [AW-1:0]              tail_o
);

  localparam logic [lpf_pkg::FREE_W-1:0] CAP = lpf_pkg::FREE_W'(RING_DEPTH - 1);

  logic [AW-1:0]  head_r, head_nxt;
  logic [AW-1:0]  tail_r, tail_nxt;
  logic [AW-1:0]  pstart_r, pstart_nxt;
  logic [AW-1:0]  count_r, count_nxt;
  logic           in_pkt_r, in_pkt_nxt;
  logic           drop_r, drop_nxt;
  logic           pop_pend_r, pop_pend_nxt;
  logic           hdr_pend_r, hdr_pend_nxt;
  logic [AW-1:0]  hdr_addr_r, hdr_addr_nxt;
  logic [AW-1:0]  hdr_val_r, hdr_val_nxt;

  logic                        acc;
  logic [lpf_pkg::BYTE_W-1:0]  data_byte;
  logic                        eop;
  logic                        busy;
  logic [AW-1:0]               used_now;
  logic [AW-1:0]               used_out;
  logic [lpf_pkg::FREE_W-1:0]  free_now;
  logic [lpf_pkg::FREE_W-1:0]  free_out;
  logic                        fits;
  logic [AW-1:0]               data_addr;
  logic [AW-1:0]               start_addr;
  logic [AW-1:0]               end_addr;
  lpf_pkg::cmd_kind_t          q_kind;
  lpf_pkg::status_t            q_status;

  assign data_byte = in_tdata[7:0];
  assign busy      = in_tdata[8];
  assign eop       = in_tlast;
  assign in_tready = !pop_pend_r && !hdr_pend_r && !q_full;
  assign acc       = in_tvalid && in_tready;

  // Free space before and after this item; occupancy wraps at the ring size
  assign used_now = head_r - tail_r;
  assign used_out = head_nxt - tail_r;
  assign free_now = CAP - lpf_pkg::FREE_W'(used_now);
  assign free_out = CAP - lpf_pkg::FREE_W'(used_out);
  assign fits     = in_pkt_r ? (free_now != '0)
                             : (free_now >= lpf_pkg::FREE_W'(2));

  // Slots used by a stored byte
  assign start_addr = in_pkt_r ? pstart_r : head_r;
  assign data_addr  = in_pkt_r ? head_r : head_r + 1'b1;
  assign end_addr   = data_addr + 1'b1;

  assign q_cmd  = '{kind: q_kind, status: q_status, free: free_out};
  assign head_o = head_r;
  assign tail_o = tail_r;

  // Classify the item and update write-side state
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    pstart_nxt   = pstart_r;
    count_nxt    = count_r;
    in_pkt_nxt   = in_pkt_r;
    drop_nxt     = drop_r;
    pop_pend_nxt = pop_pend_r;
    hdr_pend_nxt = 1'b0;
    hdr_addr_nxt = hdr_addr_r;
    hdr_val_nxt  = hdr_val_r;
    q_push       = 1'b0;
    q_kind       = lpf_pkg::CMD_RESULT;
    q_status     = lpf_pkg::ST_STORED;
    wr_en        = 1'b0;
    wr_addr      = data_addr;
    wr_data      = data_byte;

    // Finish a pending header write
    if (hdr_pend_r) begin
      wr_en   = 1'b1;
      wr_addr = hdr_addr_r;
      wr_data = lpf_pkg::BYTE_W'(hdr_val_r);
    end

    // Take back the read pointer after a pop
    if (pop_done) begin
      tail_nxt     = pop_tail;
      pop_pend_nxt = 1'b0;
    end

    if (acc) begin
      priority if (in_tuser == lpf_pkg::MODE_POP) begin
        q_push = 1'b1;
        priority if (busy) begin
          q_status = lpf_pkg::ST_POP_BUSY;
        end else if (count_r == '0) begin
          q_status = lpf_pkg::ST_POP_EMPTY;
        end else begin
          q_kind       = lpf_pkg::CMD_POP;
          count_nxt    = count_r - 1'b1;
          pop_pend_nxt = 1'b1;
        end
      end else if (drop_r) begin
        // Discard the rest of a dropped packet
        if (eop) begin
          drop_nxt = 1'b0;
          q_push   = 1'b1;
          q_status = lpf_pkg::ST_DROPPED;
        end
      end else if (!fits) begin
        // Drop: restore the write pointer
        if (in_pkt_r) begin
          head_nxt = pstart_r;
        end
        in_pkt_nxt = 1'b0;
        if (eop) begin
          q_push   = 1'b1;
          q_status = lpf_pkg::ST_DROPPED;
        end else begin
          drop_nxt = 1'b1;
        end
      end else begin
        // Store the byte, commit on the final one
        wr_en      = 1'b1;
        pstart_nxt = start_addr;
        head_nxt   = end_addr;
        in_pkt_nxt = 1'b1;
        if (eop) begin
          in_pkt_nxt   = 1'b0;
          count_nxt    = count_r + 1'b1;
          hdr_pend_nxt = 1'b1;
          hdr_addr_nxt = start_addr;
          hdr_val_nxt  = end_addr - start_addr;
          q_push       = 1'b1;
          q_status     = lpf_pkg::ST_STORED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      pstart_r   <= '0;
      count_r    <= '0;
      in_pkt_r   <= 1'b0;
      drop_r     <= 1'b0;
      pop_pend_r <= 1'b0;
      hdr_pend_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      pstart_r   <= pstart_nxt;
      count_r    <= count_nxt;
      in_pkt_r   <= in_pkt_nxt;
      drop_r     <= drop_nxt;
      pop_pend_r <= pop_pend_nxt;
      hdr_pend_r <= hdr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_addr_r <= hdr_addr_nxt;
    hdr_val_r  <= hdr_val_nxt;
  end

endmodule

>>> rtl/core/lpf_back.sv
module lpf_back #(
  parameter int RING_DEPTH = 64,
  localparam int AW = $clog2(RING_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpf_pkg::cmd_t              q_cmd,
  input  logic                       q_empty,
  output logic                       q_pop,
  input  logic [AW-1:0]              head_i,
  input  logic [AW-1:0]              tail_i,
  output logic                       pop_done,
  output logic [AW-1:0]              pop_tail,
  output logic                       rd_en,
  output logic [AW-1:0]              rd_addr,
  input  logic [lpf_pkg::BYTE_W-1:0] rd_data,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,
  output logic                       out_tlast,
  output logic [2:0]                 out_tuser
);

  localparam logic [lpf_pkg::FREE_W-1:0] CAP = lpf_pkg::FREE_W'(RING_DEPTH - 1);
  localparam logic [lpf_pkg::BYTE_W-1:0] MAX_LEN = lpf_pkg::BYTE_W'(RING_DEPTH - 2);

  lpf_pkg::back_state_t        state_r, state_nxt;
  logic [AW-1:0]               rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]               rem_r, rem_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lpf_pkg::status_t            out_status_r, out_status_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [lpf_pkg::FREE_W-1:0]  out_free_r, out_free_nxt;

  logic                        ld;
  logic [AW-1:0]               rd_addr_inc;
  logic [lpf_pkg::BYTE_W-1:0]  len_raw;
  logic [lpf_pkg::BYTE_W-1:0]  len_clamp;
  logic [AW-1:0]               len;
  logic [AW-1:0]               tail_new;
  logic [AW-1:0]               used_pop;
  logic [lpf_pkg::FREE_W-1:0]  pop_free;
  logic [lpf_pkg::BYTE_W-1:0]  out_byte;

  // Output register may load when empty or being taken
  assign ld          = !out_valid_r || out_tready;
  assign rd_addr     = (state_r == lpf_pkg::B_IDLE) ? tail_i : rd_addr_r;
  assign rd_addr_inc = rd_addr + 1'b1;

  // Decode the header: data length, clamped into range
  assign len_raw   = (rd_data == '0) ? '0 : rd_data - 1'b1;
  assign len_clamp = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
  assign len       = AW'(len_clamp);
  assign tail_new  = rd_addr_r + len;
  assign used_pop  = head_i - tail_new;
  assign pop_free  = CAP - lpf_pkg::FREE_W'(used_pop);

  // Sequence results and packet reads
  always_comb begin
    state_nxt      = state_r;
    rd_addr_nxt    = rd_addr_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    out_free_nxt   = out_free_r;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    pop_done       = 1'b0;
    pop_tail       = rd_addr_inc;

    unique case (state_r)
      lpf_pkg::B_IDLE: begin
        if (ld) begin
          out_valid_nxt = 1'b0;
          if (!q_empty) begin
            q_pop = 1'b1;
            if (q_cmd.kind == lpf_pkg::CMD_POP) begin
              // Fetch the header of the oldest packet
              rd_en       = 1'b1;
              rd_addr_nxt = rd_addr_inc;
              state_nxt   = lpf_pkg::B_HDR;
            end else begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = q_cmd.status;
              out_last_nxt   = 1'b1;
              out_free_nxt   = q_cmd.free;
            end
          end
        end
      end
      lpf_pkg::B_HDR: begin
        if (len == '0) begin
          pop_done  = 1'b1;
          pop_tail  = rd_addr_r;
          state_nxt = lpf_pkg::B_IDLE;
        end else begin
          // Fetch the first data byte
          rd_en          = 1'b1;
          rd_addr_nxt    = rd_addr_inc;
          rem_nxt        = len - 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = lpf_pkg::ST_DATA;
          out_last_nxt   = (len == AW'(1));
          out_free_nxt   = pop_free;
          if (len == AW'(1)) begin
            pop_done  = 1'b1;
            state_nxt = lpf_pkg::B_IDLE;
          end else begin
            state_nxt = lpf_pkg::B_DATA;
          end
        end
      end
      lpf_pkg::B_DATA: begin
        if (ld) begin
          // Fetch the next data byte
          rd_en          = 1'b1;
          rd_addr_nxt    = rd_addr_inc;
          rem_nxt        = rem_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = lpf_pkg::ST_DATA;
          out_last_nxt   = (rem_r == AW'(1));
          if (rem_r == AW'(1)) begin
            pop_done  = 1'b1;
            state_nxt = lpf_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = lpf_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpf_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    rem_r        <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_free_r   <= out_free_nxt;
  end

  // Data bytes come straight from the ring read register
  assign out_byte   = (out_status_r == lpf_pkg::ST_DATA) ? rd_data : '0;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_free_r, out_byte};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

>>> rtl/core/length_prefixed_packet_fifo_top.sv
// Length-prefixed packet FIFO.
// Input channel in_*: one item per handshake. in_tuser is the mode (0 push a
// byte, 1 pop the oldest packet); in_tdata carries the byte and the sink busy
// flag; in_tlast marks the final byte of a pushed packet.
// Result channel out_*: out_tuser is the status, out_tdata the popped byte and
// the free space after the item; out_tlast closes the results of one item.
// Result path: with the command queue empty, a push or refused pop passes
// through the command queue and then the output register; a popped packet
// also waits for its header to be read from the ring before its first byte.
// Throughput: push bytes go in at one per cycle while in_tready is high; a
// final byte holds the input while the header slot is written over the single
// ring write port. A pop streams one byte per cycle while the receiver takes
// them, limited by the ring read port, and holds the input until its last byte
// has been read. A two-entry command queue lets the input run ahead of the
// output. Reset clears the ring and queue pointers and counts, leaving the ring
// empty; the ring contents need no clearing. When the receiver stalls, the
// output register holds its result; the queue fills and then in_tready drops.
module length_prefixed_packet_fifo_top #(
  parameter int RING_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] sink_busy, rest zero
  input  logic        in_tlast,   // end_of_packet
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [14:8] free_space, rest zero
  output logic        out_tlast,  // last_of_run
  output logic [2:0]  out_tuser   // [2:0] status
);

  localparam int AW = $clog2(RING_DEPTH);

  logic                        q_push, q_pop, q_full, q_empty;
  lpf_pkg::cmd_t               q_in_cmd, q_out_cmd;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [lpf_pkg::BYTE_W-1:0]  wr_data, rd_data;
  logic                        pop_done;
  logic [AW-1:0]               pop_tail, head, tail;

  lpf_front #(.RING_DEPTH(RING_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in_cmd),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .pop_done  (pop_done),
    .pop_tail  (pop_tail),
    .head_o    (head),
    .tail_o    (tail)
  );

  lpf_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .head_cmd (q_out_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  lpf_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lpf_back #(.RING_DEPTH(RING_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_cmd      (q_out_cmd),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .head_i     (head),
    .tail_i     (tail),
    .pop_done   (pop_done),
    .pop_tail   (pop_tail),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/core/lpf_checker.sv
`include "length_prefixed_packet_fifo_top_macros.svh"

module lpf_checker #(
  parameter int RING_DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);

  localparam logic [6:0] CAP = 7'(RING_DEPTH - 1);

  logic [19:0] out_bus;
  logic        is_report;
  logic        report_ok;
  logic        free_ok;

  // Whole result as one vector
  assign out_bus = {out_tlast, out_tuser, out_tdata};

  // Status-only results carry no byte and close their run
  assign is_report = out_tvalid && (out_tuser != lpf_pkg::ST_DATA);
  assign report_ok = (out_tuser <= lpf_pkg::ST_DROPPED) && out_tlast
                     && (out_tdata[7:0] == '0);

  // Free space stays within the usable ring size
  assign free_ok = (out_tdata[14:8] <= CAP) && !out_tdata[15];

  // A stalled result holds still
  `LPF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_bus), "stalled result changed")

  // No result right after reset
  `LPF_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_tvalid, "result valid after reset")

  // Input is ready right after reset
  `LPF_ASSERT_ALWAYS(a_ready_after_reset, !rst_n |=> in_tready, "input not ready after reset")

  // Only data results carry a byte, and every other result closes its run
  `LPF_ASSERT(a_status_form, is_report |-> report_ok, "bad non-data result")

  // Free space never exceeds the usable ring size
  `LPF_ASSERT(a_free_range, out_tvalid |-> free_ok, "free space out of range")

endmodule

bind length_prefixed_packet_fifo_top lpf_checker #(.RING_DEPTH(RING_DEPTH)) u_lpf_checker (.*);
